/* rtl/joystick_stepper_half_step_control_defines.svh */
// Assertion macros shared by the checker of the joystick stepper control.
// No dependencies; take in by `include with the bare file name.
`ifndef JOYSTICK_STEPPER_HALF_STEP_CONTROL_DEFINES_SVH
`define JOYSTICK_STEPPER_HALF_STEP_CONTROL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/jss_pkg.sv */
// Types, register map and the half-step coil table of the joystick stepper control.
// No dependencies.
`default_nettype none
package jss_pkg;

	localparam int THR_W    = 10;
	localparam int PERIOD_W = 8;
	localparam int IVL_W    = 10;
	localparam int COIL_W   = 4;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_LOW_THR   = 3'd0;
	localparam logic [2:0] REG_HIGH_THR  = 3'd1;
	localparam logic [2:0] REG_MIN_PER   = 3'd2;
	localparam logic [2:0] REG_MAX_PER   = 3'd3;
	localparam logic [2:0] REG_SPEED_IVL = 3'd4;

	localparam logic [THR_W-1:0]    RST_LOW_THR   = 10'd256;
	localparam logic [THR_W-1:0]    RST_HIGH_THR  = 10'd778;
	localparam logic [PERIOD_W-1:0] RST_MIN_PER   = 8'd2;
	localparam logic [PERIOD_W-1:0] RST_MAX_PER   = 8'd50;
	localparam logic [IVL_W-1:0]    RST_SPEED_IVL = 10'd100;
	localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd2;

	typedef enum logic [1:0] {
		MM_INIT  = 2'd0,
		MM_CLOCK = 2'd1,
		MM_ANTI  = 2'd2
	} motor_mode_t;

	typedef enum logic [2:0] {
		SP_INIT  = 3'd0,
		SP_LOWER = 3'd1,
		SP_DZONE = 3'd2,
		SP_UPPER = 3'd3,
		SP_PAUSE = 3'd4
	} speed_mode_t;

	typedef struct packed {
		logic [THR_W-1:0]    low_thr;
		logic [THR_W-1:0]    high_thr;
		logic [PERIOD_W-1:0] min_per;
		logic [PERIOD_W-1:0] max_per;
		logic [IVL_W-1:0]    speed_ivl;
	} jss_cfg_t;

	typedef struct packed {
		motor_mode_t         motor_mode;
		logic [2:0]          phase;
		speed_mode_t         speed_mode;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] motor_elapsed;
		logic [IVL_W-1:0]    speed_elapsed;
		logic [COIL_W-1:0]   coil;
		logic                led_left;
		logic                led_right;
		logic                led_up;
		logic                led_down;
	} jss_state_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil;
		logic              led_left;
		logic              led_right;
		logic              led_up;
		logic              led_down;
		logic              stepped;
	} jss_result_t;

	function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] phase);
		logic [COIL_W-1:0] c;
		case (phase)
			3'd0:    c = 4'h1;
			3'd1:    c = 4'h3;
			3'd2:    c = 4'h2;
			3'd3:    c = 4'h6;
			3'd4:    c = 4'h4;
			3'd5:    c = 4'hC;
			3'd6:    c = 4'h8;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/jss_core.sv */
// Next-state and result logic for one tick: motor step, speed step, LED hold.
// Depends on jss_pkg.
`default_nettype none
module jss_core
	import jss_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  jss_cfg_t               cfg,
	input  jss_state_t             cur,
	input  logic [SAMPLE_BITS-1:0] x_smp,
	input  logic [SAMPLE_BITS-1:0] y_smp,
	input  logic                   paused,
	output jss_state_t             nxt,
	output jss_result_t            res
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [CMP_W-1:0]    x_c, y_c, lo_c, hi_c;
	logic [PERIOD_W-1:0] me_inc;
	logic [IVL_W-1:0]    se_inc;
	logic                motor_fire, speed_fire;
	motor_mode_t         mm_new;
	speed_mode_t         sm_new;
	logic [2:0]          phase_new;

	assign x_c  = CMP_W'(x_smp);
	assign y_c  = CMP_W'(y_smp);
	assign lo_c = CMP_W'(cfg.low_thr);
	assign hi_c = CMP_W'(cfg.high_thr);

	// saturating elapsed counters
	assign me_inc = (&cur.motor_elapsed) ? cur.motor_elapsed : cur.motor_elapsed + 1'b1;
	assign se_inc = (&cur.speed_elapsed) ? cur.speed_elapsed : cur.speed_elapsed + 1'b1;

	assign motor_fire = (me_inc >= cur.period);
	assign speed_fire = (se_inc >= cfg.speed_ivl);

	always_comb begin
		unique case (cur.motor_mode)
			MM_CLOCK: mm_new = (x_c > hi_c) ? MM_ANTI : MM_CLOCK;
			MM_ANTI:  mm_new = (x_c < lo_c) ? MM_CLOCK : MM_ANTI;
			default:  mm_new = MM_ANTI;
		endcase
		phase_new = (mm_new == MM_CLOCK) ? cur.phase - 3'd1 : cur.phase + 3'd1;
	end

	always_comb begin
		unique case (cur.speed_mode)
			SP_DZONE: begin
				if (paused)
					sm_new = SP_PAUSE;
				else if (y_c > hi_c)
					sm_new = SP_UPPER;
				else if (y_c < lo_c)
					sm_new = SP_LOWER;
				else
					sm_new = SP_DZONE;
			end
			SP_LOWER: sm_new = (y_c >= lo_c) ? SP_DZONE : SP_LOWER;
			SP_UPPER: sm_new = (y_c <= hi_c) ? SP_DZONE : SP_UPPER;
			SP_PAUSE: sm_new = paused ? SP_PAUSE : SP_DZONE;
			default:  sm_new = SP_DZONE;
		endcase
	end

	always_comb begin
		nxt = cur;
		nxt.motor_elapsed = me_inc;
		nxt.speed_elapsed = se_inc;
		if (motor_fire) begin
			nxt.motor_elapsed = '0;
			nxt.motor_mode    = mm_new;
			nxt.led_right     = (mm_new == MM_CLOCK) || paused;
			nxt.led_left      = (mm_new != MM_CLOCK) || paused;
			if (!paused) begin
				nxt.phase = phase_new;
				nxt.coil  = coil_of(phase_new);
			end
		end
		if (speed_fire) begin
			nxt.speed_elapsed = '0;
			nxt.speed_mode    = sm_new;
			nxt.led_up        = (sm_new == SP_LOWER) || (sm_new == SP_PAUSE);
			nxt.led_down      = (sm_new == SP_UPPER) || (sm_new == SP_PAUSE);
			// saturate towards the limit that applies
			if (sm_new == SP_LOWER)
				nxt.period = (cur.period > cfg.min_per) ? cur.period - 1'b1 : cfg.min_per;
			else if (sm_new == SP_UPPER)
				nxt.period = (cur.period < cfg.max_per) ? cur.period + 1'b1 : cfg.max_per;
		end
	end

	assign res.coil      = nxt.coil;
	assign res.led_left  = nxt.led_left;
	assign res.led_right = nxt.led_right;
	assign res.led_up    = nxt.led_up;
	assign res.led_down  = nxt.led_down;
	assign res.stepped   = motor_fire;

endmodule
`default_nettype wire

/* rtl/joystick_stepper_half_step_control.sv */
// Joystick stepper half-step control: one result per tick, input register then result register.
// A transferred tick waits in the input register and moves on into the result register once that is free or taken.
// Throughput: one tick per cycle; the result register stalls the input only when not taken.
// Reset (arst_n low, asynchronous) clears the valid flags, sets motor state to its reset values and restores register
// defaults; the sample and result data registers are not reset. Depends on jss_pkg and jss_core.
`default_nettype none
module joystick_stepper_half_step_control
	import jss_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_W-1:0]     paddr,
	input  wire logic [PDATA_W-1:0]     pwdata,
	output logic      [PDATA_W-1:0]     prdata,
	output logic                        pready,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] x_sample,
	input  wire logic [SAMPLE_BITS-1:0] y_sample,
	input  wire logic                   pause_button,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [COIL_W-1:0]      coil_pattern,
	output logic                        led_left,
	output logic                        led_right,
	output logic                        led_up,
	output logic                        led_down,
	output logic                        motor_stepped
);

	jss_cfg_t               cfg_q;
	jss_state_t             st_q, st_nxt;
	jss_result_t            res_nxt, res_q;
	logic                   vld_s1, out_vld_q;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic                   pause_s1;
	logic                   advance, wr_en;
	logic [2:0]             reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr   <= RST_LOW_THR;
			cfg_q.high_thr  <= RST_HIGH_THR;
			cfg_q.min_per   <= RST_MIN_PER;
			cfg_q.max_per   <= RST_MAX_PER;
			cfg_q.speed_ivl <= RST_SPEED_IVL;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LOW_THR:   cfg_q.low_thr   <= pwdata[THR_W-1:0];
				REG_HIGH_THR:  cfg_q.high_thr  <= pwdata[THR_W-1:0];
				REG_MIN_PER:   cfg_q.min_per   <= pwdata[PERIOD_W-1:0];
				REG_MAX_PER:   cfg_q.max_per   <= pwdata[PERIOD_W-1:0];
				REG_SPEED_IVL: cfg_q.speed_ivl <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW_THR:   prdata = PDATA_W'(cfg_q.low_thr);
			REG_HIGH_THR:  prdata = PDATA_W'(cfg_q.high_thr);
			REG_MIN_PER:   prdata = PDATA_W'(cfg_q.min_per);
			REG_MAX_PER:   prdata = PDATA_W'(cfg_q.max_per);
			REG_SPEED_IVL: prdata = PDATA_W'(cfg_q.speed_ivl);
			default:       prdata = '0;
		endcase
	end

	// move the held tick into the result register when that is free or being taken
	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1     <= x_sample;
			y_s1     <= y_sample;
			pause_s1 <= pause_button;
		end
	end

	jss_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.cfg    (cfg_q),
		.cur    (st_q),
		.x_smp  (x_s1),
		.y_smp  (y_s1),
		.paused (pause_s1),
		.nxt    (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.motor_mode    <= MM_INIT;
			st_q.phase         <= '0;
			st_q.speed_mode    <= SP_INIT;
			st_q.period        <= RST_PERIOD;
			st_q.motor_elapsed <= '0;
			st_q.speed_elapsed <= '0;
			st_q.coil          <= '0;
			st_q.led_left      <= 1'b0;
			st_q.led_right     <= 1'b0;
			st_q.led_up        <= 1'b0;
			st_q.led_down      <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (advance)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid     = out_vld_q;
	assign coil_pattern  = res_q.coil;
	assign led_left      = res_q.led_left;
	assign led_right     = res_q.led_right;
	assign led_up        = res_q.led_up;
	assign led_down      = res_q.led_down;
	assign motor_stepped = res_q.stepped;

endmodule
`default_nettype wire

/* rtl/jss_checker.sv */
// Port-level checker for the joystick stepper control, bound to the top level.
// Depends on jss_pkg and joystick_stepper_half_step_control_defines.svh.
`default_nettype none
`include "joystick_stepper_half_step_control_defines.svh"
module jss_checker
	import jss_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [COIL_W-1:0] coil_pattern,
	input wire logic              led_left,
	input wire logic              led_right,
	input wire logic              motor_stepped
);

	localparam int CHK_SAMPLE_BITS = SAMPLE_BITS;

	logic coil_legal;
	logic sample_width_ok;

	assign sample_width_ok = (CHK_SAMPLE_BITS > 0);
	assign coil_legal = (coil_pattern == 4'h0) || (coil_pattern == 4'h1) ||
		(coil_pattern == 4'h3) || (coil_pattern == 4'h2) || (coil_pattern == 4'h6) ||
		(coil_pattern == 4'h4) || (coil_pattern == 4'hC) || (coil_pattern == 4'h8) ||
		(coil_pattern == 4'h9);

	// a held result stays until its transfer
	`JSS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(coil_pattern) && $stable(motor_stepped))
	// an empty result register never blocks the input
	`JSS_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid && sample_width_ok, in_ready)
	// coils only ever show a half-step table entry or the reset pattern
	`JSS_ASSERT_IMP(a_coil_legal, clk, arst_n, out_valid, coil_legal)
	// a motor step always lights at least one direction LED
	`JSS_ASSERT_IMP(a_step_led, clk, arst_n, out_valid && motor_stepped, led_left || led_right)

endmodule

bind joystick_stepper_half_step_control jss_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_jss_checker (.*);
`default_nettype wire
